### hw/rtl/lbmu_pkg.sv
`default_nettype none
package lbmu_pkg;

	localparam int WORD_W = 48;
	localparam int ID_W   = 6;
	localparam int MC_BIT = 40;

	localparam logic [WORD_W-1:0] ROW_RESET = 48'h01_0000_0000_00;

	// operation codes
	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SELF  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [1:0] CFG_SYMMETRIC  = 2'd1;

	typedef struct packed {
		logic [ID_W-1:0]   node_count;
		logic              symmetric;
		logic [WORD_W-1:0] use_mask;
	} cfg_t;

	// request token walking the cell chain
	typedef struct packed {
		logic              valid;
		logic [1:0]        op;
		logic              add;
		logic              s_all;
		logic              r_all;
		logic [ID_W-1:0]   s_idx;
		logic [ID_W-1:0]   r_idx;
		logic [WORD_W-1:0] value;
		logic [1:0]        status;
		logic              recv;
		logic [WORD_W-1:0] word;
	} tok_t;

	// ids at and above the multicast bit sit one position higher
	function automatic logic [WORD_W-1:0] node_mask(input logic [ID_W-1:0] id);
		logic [ID_W:0] pos;
		pos = (id < ID_W'(MC_BIT)) ? {1'b0, id} : {1'b0, id} + 7'd1;
		if (pos < 7'(WORD_W))
			node_mask = {{(WORD_W-1){1'b0}}, 1'b1} << pos;
		else
			node_mask = '0;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lbmu_cell.sv
`default_nettype none
module lbmu_cell #(
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire lbmu_pkg::cfg_t cfg,
	input  wire lbmu_pkg::tok_t tok_i,
	output lbmu_pkg::tok_t      tok_o
);

	localparam logic [lbmu_pkg::ID_W-1:0] K = lbmu_pkg::ID_W'(IDX);

	logic [lbmu_pkg::WORD_W-1:0] row_q, row_d;
	logic [lbmu_pkg::WORD_W-1:0] bit_k, bit_s, bit_r, bit_x, opm;
	logic [lbmu_pkg::ID_W-1:0]   x_id;
	logic                        in_use, rowsel, colsel;
	lbmu_pkg::tok_t              tok_d, tok_q;
	logic                        vld_q;

	always_comb begin
		bit_k  = lbmu_pkg::node_mask(K);
		bit_s  = lbmu_pkg::node_mask(tok_i.s_idx);
		bit_r  = lbmu_pkg::node_mask(tok_i.r_idx);
		x_id   = tok_i.s_all ? tok_i.r_idx : tok_i.s_idx;
		bit_x  = lbmu_pkg::node_mask(x_id);
		in_use = K < cfg.node_count;
		opm    = tok_i.add ? (row_q | cfg.use_mask) : (row_q & ~cfg.use_mask);
		rowsel = tok_i.r_all || cfg.symmetric;
		colsel = tok_i.s_all || cfg.symmetric;
		row_d  = row_q;
		if (tok_i.valid && tok_i.status == lbmu_pkg::ST_OK) begin
			case (tok_i.op)
				lbmu_pkg::OP_LOAD: begin
					if (K == tok_i.s_idx)
						row_d = tok_i.value;
				end
				lbmu_pkg::OP_UPDATE: begin
					if (tok_i.s_all && tok_i.r_all) begin
						if (in_use)
							row_d = opm & ~bit_k;
					end else if (tok_i.s_all || tok_i.r_all) begin
						// row part on node x, column part on bit x, own bit last
						if (K == x_id && rowsel)
							row_d = opm;
						if (in_use && colsel)
							row_d = tok_i.add ? (row_d | bit_x) : (row_d & ~bit_x);
						if (K == x_id)
							row_d = row_d & ~bit_x;
					end else begin
						if (K == tok_i.s_idx)
							row_d = tok_i.add ? (row_q | bit_r) : (row_q & ~bit_r);
						if (cfg.symmetric && K == tok_i.r_idx)
							row_d = tok_i.add ? (row_q | bit_s) : (row_q & ~bit_s);
					end
				end
				default: ;
			endcase
		end
		tok_d = tok_i;
		if (in_use && (row_d & bit_s) != '0)
			tok_d.recv = 1'b1;
		if (K == tok_i.s_idx)
			tok_d.word = row_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= lbmu_pkg::ROW_RESET;
			vld_q <= 1'b0;
		end else if (advance) begin
			if (tok_i.valid)
				row_q <= row_d;
			vld_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			tok_q <= tok_d;
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = vld_q;
	end

endmodule
`default_nettype wire

### hw/rtl/link_bitmap_matrix_update_top.sv
`default_nettype none
// channel | handshake            | payload
// in      | in_valid / in_ready   | operation add_link sender_all receiver_all
//         |                       | sender_index receiver_index row_value
// out     | out_valid / out_ready | status can_send can_receive row_word
// cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One request walks the row cells one per cycle while the chain advances, then lands
// in the output register and raises out_valid. in_ready is low until then, so a new
// request cannot start before the last one has left the cell chain.
// Reset: every row holds the multicast bit only, node_count = 0, symmetric = 0.
// A result stalled in the output register freezes the chain when the next
// result reaches its end; in_ready stays low meanwhile.
module link_bitmap_matrix_update_top #(
	parameter int MAX_NODES = 46
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        add_link,
	input  wire logic        sender_all,
	input  wire logic        receiver_all,
	input  wire logic [5:0]  sender_index,
	input  wire logic [5:0]  receiver_index,
	input  wire logic [47:0] row_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             can_send,
	output logic             can_receive,
	output logic [47:0]      row_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data
);

	localparam logic [lbmu_pkg::ID_W-1:0] MAX_ID = lbmu_pkg::ID_W'(MAX_NODES);

	logic [lbmu_pkg::ID_W-1:0] node_count_q;
	logic                      symmetric_q;
	lbmu_pkg::cfg_t            cfg;
	lbmu_pkg::tok_t            tok [0:MAX_NODES];
	lbmu_pkg::tok_t            tail;
	logic [MAX_NODES-1:0]      vld_vec;
	logic                      busy_q, advance, accept, s_bad, r_bad, s_ok;
	logic [1:0]                in_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			symmetric_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lbmu_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data;
				lbmu_pkg::CFG_SYMMETRIC:  symmetric_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.node_count = node_count_q;
		cfg.symmetric  = symmetric_q;
		cfg.use_mask   = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (lbmu_pkg::ID_W'(i) < node_count_q)
				cfg.use_mask = cfg.use_mask | lbmu_pkg::node_mask(lbmu_pkg::ID_W'(i));
		end
	end

	// status is known at accept; cells only act on an ok request
	always_comb begin
		s_bad = sender_index >= MAX_ID;
		r_bad = receiver_index >= MAX_ID;
		in_status = lbmu_pkg::ST_OK;
		if (operation == lbmu_pkg::OP_UPDATE) begin
			if (sender_all && receiver_all)
				in_status = lbmu_pkg::ST_OK;
			else if (sender_all)
				in_status = r_bad ? lbmu_pkg::ST_RANGE : lbmu_pkg::ST_OK;
			else if (receiver_all)
				in_status = s_bad ? lbmu_pkg::ST_RANGE : lbmu_pkg::ST_OK;
			else if (s_bad || r_bad)
				in_status = lbmu_pkg::ST_RANGE;
			else if (sender_index == receiver_index)
				in_status = lbmu_pkg::ST_SELF;
		end else if (s_bad) begin
			in_status = lbmu_pkg::ST_RANGE;
		end
	end

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign tail     = tok[MAX_NODES];
	assign advance  = !(tail.valid && out_valid && !out_ready);

	always_comb begin
		tok[0].valid  = accept;
		tok[0].op     = operation;
		tok[0].add    = add_link;
		tok[0].s_all  = sender_all;
		tok[0].r_all  = receiver_all;
		tok[0].s_idx  = sender_index;
		tok[0].r_idx  = receiver_index;
		tok[0].value  = row_value;
		tok[0].status = in_status;
		tok[0].recv   = 1'b0;
		tok[0].word   = '0;
	end

	for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
		lbmu_cell #(.IDX(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.cfg    (cfg),
			.tok_i  (tok[k]),
			.tok_o  (tok[k+1])
		);
		assign vld_vec[k] = tok[k+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (tail.valid && advance)
				busy_q <= 1'b0;
			if (tail.valid && advance)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	assign s_ok = tail.s_idx < MAX_ID;

	always_ff @(posedge clk) begin
		if (tail.valid && advance) begin
			status      <= tail.status;
			row_word    <= s_ok ? tail.word : '0;
			can_send    <= s_ok && ((tail.word & cfg.use_mask) != '0);
			can_receive <= s_ok && tail.recv;
		end
	end

	// at most one request in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec))
		else $error("more than one request in the cell chain");

	a_busy_token: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (vld_vec != '0))
		else $error("busy flag disagrees with chain contents");

	a_out_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_vec[MAX_NODES-1]))
		else $error("result registered without a request at the chain end");

endmodule
`default_nettype wire
